[sv/ffha_pkg.sv]
package ffha_pkg;

   // Widths of the request and response fields.
   localparam int FIELD_W  = 18;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;

   // Default heap geometry.
   localparam int HEAP_BYTES_DEF   = 131200;
   localparam int HEADER_BYTES_DEF = 8;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_ALLOC = 2'd0;
   localparam action_type ACT_FREE  = 2'd1;
   localparam action_type ACT_INIT  = 2'd2;

   localparam status_type ST_ALLOC   = 3'd0;
   localparam status_type ST_FAIL    = 3'd1;
   localparam status_type ST_FREED   = 3'd2;
   localparam status_type ST_IGNORED = 3'd3;
   localparam status_type ST_INIT    = 3'd4;

endpackage

[sv/ffha_hdr_ram.sv]
// Single-port header store with a registered read port.
module ffha_hdr_ram #(
   parameter int DEPTH = 32800,
   parameter int AW    = 16,
   parameter int DW    = 19
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/first_fit_heap_allocator.sv]
// Channel   | Direction | Ports                                            | Handshake
// ----------+-----------+--------------------------------------------------+-------------
// request   | in        | req_action, req_request_bytes, req_free_offset   | req_valid, req_stall
// response  | out       | rsp_status, rsp_payload_offset                   | rsp_valid, rsp_stall
//
// Every request produces exactly one response. An allocate walks the block headers in
// first-fit order; a free walks the blocks ahead of the target, then merges with free
// neighbours; an initialise rewrites the header of word 0. The walk is paced by the single
// port of the header memory: one header read, then one decision, per block.
// After reset the block writes the header of word 0 with req_stall high.
// A response that is stalled is held in the output register; the sequencer waits for it to
// be taken before it delivers the next one.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ffha_pkg::action_type         req_action,
   input  logic [ffha_pkg::FIELD_W-1:0] req_request_bytes,
   input  logic [ffha_pkg::FIELD_W-1:0] req_free_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ffha_pkg::status_type         rsp_status,
   output logic [ffha_pkg::FIELD_W-1:0] rsp_payload_offset
);

   // Header size rounded up to whole words, so that every block starts on a word.
   localparam int HDR   = (HEADER_BYTES + 3) / 4 * 4;
   localparam int WORDS = (HEAP_BYTES + 3) / 4;
   // Width of a block size, and of one header entry (busy mark on top).
   localparam int SW    = $clog2(HEAP_BYTES + 1);
   localparam int EW    = SW + 1;
   // Word address width of the header memory.
   localparam int WAW   = $clog2(WORDS);
   // Byte offsets during a walk can reach twice the heap size.
   localparam int OW    = SW + 1;
   // Common width for sums and compares between offsets, sizes and request fields.
   localparam int CW    = ((OW > ffha_pkg::FIELD_W) ? OW : ffha_pkg::FIELD_W) + 2;

   localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
   localparam logic [CW-1:0] HDR_C  = CW'(HDR);

   typedef enum logic [3:0] {
      S_BOOT,
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_A_SPLIT,
      S_F_RD,
      S_F_CHK,
      S_F_NODE,
      S_F_SRD,
      S_F_SCHK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Walk position and per-request working values.
   logic [OW-1:0] off_ff, off_in;
   logic [CW-1:0] need_ff, need_in;
   logic [CW-1:0] need_hdr_ff, need_hdr_in;
   logic [CW-1:0] target_ff, target_in;
   logic          has_prev_ff, has_prev_in;
   logic          prev_busy_ff, prev_busy_in;
   logic [SW-1:0] prev_off_ff, prev_off_in;
   logic [SW-1:0] prev_size_ff, prev_size_in;
   logic [SW-1:0] node_ff, node_in;
   logic [SW-1:0] acc_ff, acc_in;

   // Result waiting for the output register, and the output register itself.
   ffha_pkg::status_type         res_status_ff, res_status_in;
   logic [ffha_pkg::FIELD_W-1:0] res_pay_ff, res_pay_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ffha_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ffha_pkg::FIELD_W-1:0] rsp_pay_ff, rsp_pay_in;

   // Header memory port.
   logic           mem_we;
   logic [WAW-1:0] mem_addr;
   logic [EW-1:0]  mem_wdata;
   logic [EW-1:0]  rd_data;
   logic [SW-1:0]  rd_size;
   logic           rd_busy;

   // Shared arithmetic.
   logic [CW-1:0] off_c;
   logic [CW-1:0] size_c;
   logic [CW-1:0] need_calc;
   logic [CW-1:0] pay_sum;
   logic [CW-1:0] split_off;
   logic [CW-1:0] walk_next;
   logic [CW-1:0] succ_off;

   ffha_hdr_ram #(
      .DEPTH (WORDS),
      .AW    (WAW),
      .DW    (EW)
   ) u_hdr_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rd_data)
   );

   assign rd_size = rd_data[SW-1:0];
   assign rd_busy = rd_data[SW];

   assign off_c     = CW'(off_ff);
   assign size_c    = CW'(rd_size);
   // Round the request up to whole words and add the header.
   assign need_calc = ((CW'(req_request_bytes) + CW'(3)) & ~CW'(3)) + HDR_C;
   assign pay_sum   = off_c + HDR_C;
   assign split_off = off_c + need_ff;
   assign walk_next = off_c + size_c;
   assign succ_off  = CW'(node_ff) + CW'(acc_ff);

   always_comb begin
      state_in      = state_ff;
      off_in        = off_ff;
      need_in       = need_ff;
      need_hdr_in   = need_hdr_ff;
      target_in     = target_ff;
      has_prev_in   = has_prev_ff;
      prev_busy_in  = prev_busy_ff;
      prev_off_in   = prev_off_ff;
      prev_size_in  = prev_size_ff;
      node_in       = node_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      mem_we        = 1'b0;
      mem_addr      = off_ff[WAW+1:2];
      mem_wdata     = '0;

      // A response that the consumer takes frees the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_BOOT: begin
            // Lay down the single free block that spans the heap.
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = {1'b0, SW'(HEAP_BYTES)};
            state_in  = S_IDLE;
         end

         S_IDLE: begin
            if (req_valid) begin
               res_pay_in = '0;
               off_in     = '0;
               unique case (req_action)
                  ffha_pkg::ACT_ALLOC: begin
                     need_in     = need_calc;
                     need_hdr_in = need_calc + HDR_C;
                     if (req_request_bytes == '0) begin
                        res_status_in = ffha_pkg::ST_FAIL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_A_RD;
                     end
                  end
                  ffha_pkg::ACT_FREE: begin
                     target_in   = CW'(req_free_offset) - HDR_C;
                     has_prev_in = 1'b0;
                     if (CW'(req_free_offset) < HDR_C) begin
                        res_status_in = ffha_pkg::ST_IGNORED;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_F_RD;
                     end
                  end
                  ffha_pkg::ACT_INIT: begin
                     mem_we        = 1'b1;
                     mem_addr      = '0;
                     mem_wdata     = {1'b0, SW'(HEAP_BYTES)};
                     res_status_in = ffha_pkg::ST_INIT;
                     state_in      = S_DONE;
                  end
                  default: begin
                     res_status_in = ffha_pkg::ST_IGNORED;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         S_A_RD: begin
            // The header read at the current offset is issued here.
            if (off_c >= HEAP_C) begin
               res_status_in = ffha_pkg::ST_FAIL;
               state_in      = S_DONE;
            end else begin
               state_in = S_A_CHK;
            end
         end

         S_A_CHK: begin
            if (rd_size == '0) begin
               res_status_in = ffha_pkg::ST_FAIL;
               state_in      = S_DONE;
            end else if (!rd_busy && need_ff == size_c) begin
               mem_we        = 1'b1;
               mem_wdata     = {1'b1, rd_size};
               res_pay_in    = pay_sum[ffha_pkg::FIELD_W-1:0];
               res_status_in = ffha_pkg::ST_ALLOC;
               state_in      = S_DONE;
            end else if (!rd_busy && need_hdr_ff <= size_c) begin
               // Write the split-off remainder first, then mark the taken part.
               mem_we    = 1'b1;
               mem_addr  = split_off[WAW+1:2];
               mem_wdata = {1'b0, SW'(size_c - need_ff)};
               state_in  = S_A_SPLIT;
            end else begin
               off_in   = walk_next[OW-1:0];
               state_in = S_A_RD;
            end
         end

         S_A_SPLIT: begin
            mem_we        = 1'b1;
            mem_wdata     = {1'b1, need_ff[SW-1:0]};
            res_pay_in    = pay_sum[ffha_pkg::FIELD_W-1:0];
            res_status_in = ffha_pkg::ST_ALLOC;
            state_in      = S_DONE;
         end

         S_F_RD: begin
            // The header at the current offset is read in every case.
            if (off_c < HEAP_C && off_c < target_ff) begin
               state_in = S_F_CHK;
            end else if (off_c == target_ff && off_c < HEAP_C) begin
               state_in = S_F_NODE;
            end else begin
               res_status_in = ffha_pkg::ST_IGNORED;
               state_in      = S_DONE;
            end
         end

         S_F_CHK: begin
            if (rd_size == '0) begin
               res_status_in = ffha_pkg::ST_IGNORED;
               state_in      = S_DONE;
            end else begin
               prev_off_in  = off_ff[SW-1:0];
               prev_busy_in = rd_busy;
               prev_size_in = rd_size;
               has_prev_in  = 1'b1;
               off_in       = walk_next[OW-1:0];
               state_in     = S_F_RD;
            end
         end

         S_F_NODE: begin
            // Clear the busy mark, merging into a free predecessor where there is one.
            mem_we = 1'b1;
            if (has_prev_ff && !prev_busy_ff) begin
               node_in   = prev_off_ff;
               acc_in    = rd_size + prev_size_ff;
               mem_addr  = prev_off_ff[WAW+1:2];
               mem_wdata = {1'b0, rd_size + prev_size_ff};
            end else begin
               node_in   = off_ff[SW-1:0];
               acc_in    = rd_size;
               mem_wdata = {1'b0, rd_size};
            end
            state_in = S_F_SRD;
         end

         S_F_SRD: begin
            if (succ_off < HEAP_C) begin
               mem_addr = succ_off[WAW+1:2];
               state_in = S_F_SCHK;
            end else begin
               res_status_in = ffha_pkg::ST_FREED;
               state_in      = S_DONE;
            end
         end

         S_F_SCHK: begin
            // Absorb a free successor.
            if (!rd_busy && rd_size != '0) begin
               mem_we    = 1'b1;
               mem_addr  = node_ff[WAW+1:2];
               mem_wdata = {1'b0, acc_ff + rd_size};
            end
            res_status_in = ffha_pkg::ST_FREED;
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pay_in    = res_pay_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff        <= off_in;
      need_ff       <= need_in;
      need_hdr_ff   <= need_hdr_in;
      target_ff     <= target_in;
      has_prev_ff   <= has_prev_in;
      prev_busy_ff  <= prev_busy_in;
      prev_off_ff   <= prev_off_in;
      prev_size_ff  <= prev_size_in;
      node_ff       <= node_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_pay_ff;

endmodule

[bench/tb_first_fit_heap_allocator.sv]
module tb_first_fit_heap_allocator;

   // Heap geometry as the block is built by default. The header is kept on a word boundary.
   localparam int unsigned HEAP_SIZE  = ffha_pkg::HEAP_BYTES_DEF;
   localparam int unsigned HDR        = (ffha_pkg::HEADER_BYTES_DEF + 3) / 4 * 4;
   localparam int unsigned HEAP_WORDS = (HEAP_SIZE + 3) / 4;
   localparam bit [31:0]   BUSY_FLAG  = 32'h8000_0000;
   localparam bit [31:0]   SIZE_MASK  = 32'h7FFF_FFFF;

   // The one action code that the block does not use; it must be answered as ignored.
   localparam ffha_pkg::action_type ACT_UNUSED = 2'd3;

   typedef struct packed {
      ffha_pkg::action_type         act;
      logic [ffha_pkg::FIELD_W-1:0] bytes;
      logic [ffha_pkg::FIELD_W-1:0] offset;
      logic                         known;    // expected response typed into the table
      ffha_pkg::status_type         want_status;
      logic [ffha_pkg::FIELD_W-1:0] want_payload;
   } step_row_type;

   typedef struct packed {
      ffha_pkg::status_type         status;
      logic [ffha_pkg::FIELD_W-1:0] payload;
   } response_type;

   // A payload handed out by the block, with the byte count that produced it.
   typedef struct packed {
      logic [ffha_pkg::FIELD_W-1:0] offset;
      logic [ffha_pkg::FIELD_W-1:0] bytes;
   } grant_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   ffha_pkg::action_type         req_action = ffha_pkg::ACT_ALLOC;
   logic [ffha_pkg::FIELD_W-1:0] req_request_bytes = '0;
   logic [ffha_pkg::FIELD_W-1:0] req_free_offset = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   ffha_pkg::status_type         rsp_status;
   logic [ffha_pkg::FIELD_W-1:0] rsp_payload_offset;

   // Our own copy of the heap: one header per word, busy flag in bit 31.
   bit [31:0]      shadow_heap [HEAP_WORDS];
   response_type   pending_responses [$];
   grant_type      live_grants [$];
   grant_type      released_grants [$];

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   // A long hold-off is asked for by bumping hold_seq; the stall process counts it down.
   int unsigned hold_len = 0;
   int unsigned hold_seq = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_off_cycles = 0;
   int unsigned error_count = 0;
   int unsigned response_count = 0;

   // The directed opening. Rows whose answer is plain from the heap layout carry it;
   // the others are left to the predictor.
   step_row_type directed_steps [25] = '{
      // A zero-byte request always fails.
      '{ffha_pkg::ACT_ALLOC, 18'd0,      18'd0,      1'b1, ffha_pkg::ST_FAIL,    18'd0},
      // Exactly the whole heap less one header: an exact fit at the start.
      '{ffha_pkg::ACT_ALLOC, 18'd131192, 18'd0,      1'b1, ffha_pkg::ST_ALLOC,   18'd8},
      '{ffha_pkg::ACT_ALLOC, 18'd1,      18'd0,      1'b1, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd8,      1'b1, ffha_pkg::ST_FREED,   18'd0},
      // Oversized, all ones, and a fit that would leave less than a header behind.
      '{ffha_pkg::ACT_ALLOC, 18'd131193, 18'd0,      1'b1, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'h3FFFF,  18'd0,      1'b1, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd131188, 18'd0,      1'b1, ffha_pkg::ST_FAIL,    18'd0},
      // Offsets below the header and far beyond the heap are not block starts.
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd0,      1'b1, ffha_pkg::ST_IGNORED, 18'd0},
      '{ffha_pkg::ACT_FREE,  18'd0,      18'h3FFFF,  1'b1, ffha_pkg::ST_IGNORED, 18'd0},
      '{ACT_UNUSED,          18'h3FFFF,  18'h3FFFF,  1'b1, ffha_pkg::ST_IGNORED, 18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd1,      18'd0,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd100,    18'd0,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd3,      18'd0,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      // A misaligned offset inside a busy block.
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd21,     1'b1, ffha_pkg::ST_IGNORED, 18'd0},
      // Free the middle block twice, then reuse the hole with an exact fit.
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd20,     1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd20,     1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd100,    18'd0,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      // Free the first block, then the second so that it merges backwards.
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd8,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd20,     1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd131000, 18'd0,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_INIT,  18'd0,      18'd0,      1'b1, ffha_pkg::ST_INIT,    18'd0},
      // Freeing the lone free block after an initialise is still reported as freed.
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd8,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_ALLOC, 18'd131072, 18'd0,      1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_FREE,  18'd0,      18'd131088, 1'b0, ffha_pkg::ST_FAIL,    18'd0},
      '{ffha_pkg::ACT_INIT,  18'd0,      18'd0,      1'b1, ffha_pkg::ST_INIT,    18'd0}
   };

   first_fit_heap_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_free_offset    (req_free_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Headers outside the heap read as zero and are never written, just as a broken
   // chain would look to the walk.
   function automatic bit [31:0] header_at(input int unsigned pos);
      return ((pos >> 2) < HEAP_WORDS) ? shadow_heap[pos >> 2] : 32'd0;
   endfunction

   function automatic void set_header(input int unsigned pos, input bit [31:0] value);
      if ((pos >> 2) < HEAP_WORDS) begin
         shadow_heap[pos >> 2] = value;
      end
   endfunction

   // Works out the response to one request and updates the shadow heap to match.
   function automatic void predict_heap_response(input ffha_pkg::action_type act,
                                                 input logic [ffha_pkg::FIELD_W-1:0] bytes,
                                                 input logic [ffha_pkg::FIELD_W-1:0] offset,
                                                 output ffha_pkg::status_type st,
                                                 output logic [ffha_pkg::FIELD_W-1:0] pay);
      int unsigned words;
      int unsigned need;
      int unsigned pos;
      int unsigned size;
      int unsigned target;
      int unsigned prev;
      int unsigned node;
      int unsigned succ;
      bit [31:0]   head;
      bit          has_prev;
      bit          done;
      st  = ffha_pkg::ST_IGNORED;
      pay = '0;
      case (act)
         ffha_pkg::ACT_ALLOC: begin
            st    = ffha_pkg::ST_FAIL;
            words = (32'(bytes) + 32'd3) >> 2;
            if (words != 0) begin
               need = words * 4 + HDR;
               pos  = 0;
               done = 1'b0;
               // First fit: an exact match, or a block that still leaves room for a
               // free block with at least its header once the request is split off.
               while (!done && pos < HEAP_SIZE) begin
                  head = header_at(pos);
                  size = head & SIZE_MASK;
                  if (size == 0) begin
                     done = 1'b1;
                  end else begin
                     if (!head[31] && (need == size || need + HDR <= size)) begin
                        if (need != size) begin
                           set_header(pos + need, size - need);
                        end
                        set_header(pos, need | BUSY_FLAG);
                        st   = ffha_pkg::ST_ALLOC;
                        pay  = 18'(pos + HDR);
                        done = 1'b1;
                     end
                     pos += size;
                  end
               end
            end
         end
         ffha_pkg::ACT_FREE: begin
            if (offset >= HDR) begin
               target   = 32'(offset) - HDR;
               pos      = 0;
               prev     = 0;
               has_prev = 1'b0;
               done     = 1'b0;
               while (!done && pos < HEAP_SIZE && pos < target) begin
                  size = header_at(pos) & SIZE_MASK;
                  if (size == 0) begin
                     done = 1'b1;
                  end else begin
                     prev     = pos;
                     has_prev = 1'b1;
                     pos     += size;
                  end
               end
               if (!done && pos == target && pos < HEAP_SIZE) begin
                  node = pos;
                  size = header_at(node) & SIZE_MASK;
                  set_header(node, size);
                  // Merge backwards first, then forwards from whichever block survived.
                  head = header_at(prev);
                  if (has_prev && !head[31]) begin
                     size += head & SIZE_MASK;
                     node  = prev;
                     set_header(node, size);
                  end
                  succ = node + size;
                  if (succ < HEAP_SIZE) begin
                     head = header_at(succ);
                     if (!head[31] && (head & SIZE_MASK) != 0) begin
                        set_header(node, size + (head & SIZE_MASK));
                     end
                  end
                  st = ffha_pkg::ST_FREED;
               end
            end
         end
         ffha_pkg::ACT_INIT: begin
            set_header(0, HEAP_SIZE);
            st = ffha_pkg::ST_INIT;
         end
         default: begin
            st = ffha_pkg::ST_IGNORED;
         end
      endcase
   endfunction

   // Random requests. Most are allocations and frees of payloads the block handed out;
   // the rest are stale frees, bad offsets, unused codes and the odd initialise.
   function automatic step_row_type draw_random_request();
      step_row_type row;
      int unsigned  dice;
      int unsigned  shape;
      int unsigned  pick;
      row.act          = ffha_pkg::ACT_ALLOC;
      row.bytes        = 18'($urandom);
      row.offset       = 18'($urandom);
      row.known        = 1'b0;
      row.want_status  = ffha_pkg::ST_FAIL;
      row.want_payload = '0;
      dice = $urandom_range(99);
      if (dice < 1) begin
         row.act = ffha_pkg::ACT_INIT;
      end else if (dice < 3) begin
         row.act = ACT_UNUSED;
      end else if (dice < 7) begin
         row.act = ffha_pkg::ACT_FREE;
         if (live_grants.size() != 0 && dice < 5) begin
            pick = $urandom_range(live_grants.size() - 1);
            if (dice == 3) begin
               row.offset = live_grants[pick].offset - 18'd4;
            end else begin
               row.offset = live_grants[pick].offset + 18'($urandom_range(3, 1));
            end
         end
      end else if (dice < 12 && released_grants.size() != 0) begin
         row.act    = ffha_pkg::ACT_FREE;
         row.offset = released_grants[$urandom_range(released_grants.size() - 1)].offset;
      end else if (live_grants.size() != 0 && (live_grants.size() > 40 || dice < 48)) begin
         pick       = $urandom_range(live_grants.size() - 1);
         row.act    = ffha_pkg::ACT_FREE;
         row.offset = live_grants[pick].offset;
         row.bytes  = live_grants[pick].bytes;
         live_grants.delete(pick);
      end else begin
         shape = $urandom_range(99);
         if (shape < 2) begin
            row.bytes = '0;
         end else if (shape < 12 && released_grants.size() != 0) begin
            // Same size as something freed recently, so that exact fits turn up.
            row.bytes = released_grants[$urandom_range(released_grants.size() - 1)].bytes;
         end else if (shape < 15) begin
            row.bytes = 18'($urandom);
         end else if (shape < 20) begin
            row.bytes = 18'($urandom_range(40000, 4096));
         end else if (shape < 45) begin
            row.bytes = 18'($urandom_range(1024, 1));
         end else begin
            row.bytes = 18'($urandom_range(64, 1));
         end
      end
      return row;
   endfunction

   // Offers one request, holds it until the block takes it, then records what the
   // response must be and keeps the list of handed-out payloads up to date.
   task automatic issue_request(input step_row_type row, output ffha_pkg::status_type st);
      logic [ffha_pkg::FIELD_W-1:0] pay;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= row.act;
      req_request_bytes <= row.bytes;
      req_free_offset   <= row.offset;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_heap_response(row.act, row.bytes, row.offset, st, pay);
      if (row.known) begin
         pending_responses.push_back('{row.want_status, row.want_payload});
      end else begin
         pending_responses.push_back('{st, pay});
      end
      if (row.act == ffha_pkg::ACT_ALLOC && st == ffha_pkg::ST_ALLOC) begin
         live_grants.push_back('{pay, row.bytes});
      end else if (row.act == ffha_pkg::ACT_FREE && st == ffha_pkg::ST_FREED) begin
         released_grants.push_back('{row.offset, row.bytes});
         if (released_grants.size() > 32) begin
            released_grants.delete(0);
         end
      end else if (row.act == ffha_pkg::ACT_INIT) begin
         live_grants.delete();
         released_grants.delete();
      end
   endtask

   // Stops offering and waits for every outstanding response. Sampled on the falling
   // edge so that it never races the checker.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // One phase of random traffic. Requests that the block merely ignores are not
   // counted towards the phase length.
   task automatic run_phase(input int unsigned count, input int unsigned idle,
                            input int unsigned stall, input int unsigned hold);
      int unsigned          taken;
      ffha_pkg::status_type st;
      @(negedge clock);
      idle_pct  = idle;
      stall_pct = stall;
      if (hold != 0) begin
         hold_len = hold;
         hold_seq++;
      end
      @(posedge clock);
      taken = 0;
      while (taken < count) begin
         issue_request(draw_random_request(), st);
         if (st != ffha_pkg::ST_IGNORED) begin
            taken++;
         end
      end
      drain_responses();
   endtask

   // Response side back-pressure. A long hold-off counts itself down here, so that the
   // block fills up and has to stall its request side.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen       <= hold_seq;
         hold_off_cycles <= hold_len;
         rsp_stall       <= 1'b1;
      end else if (hold_off_cycles != 0) begin
         rsp_stall       <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Every response taken is matched against the oldest outstanding expectation.
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (pending_responses.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("response %0d not expected: status %0d offset %0d",
                        response_count, rsp_status, rsp_payload_offset);
            end
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status || rsp_payload_offset !== want.payload) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("response %0d: expected status %0d offset %0d,",
                           response_count, want.status, want.payload,
                           " got status %0d offset %0d",
                           rsp_status, rsp_payload_offset);
               end
            end
         end
      end
   end

   initial begin
      ffha_pkg::status_type st;
      foreach (shadow_heap[w]) begin
         shadow_heap[w] = '0;
      end
      shadow_heap[0] = HEAP_SIZE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         issue_request(directed_steps[i], st);
      end
      drain_responses();

      // Back to back, then each side idling, then both.
      run_phase(150, 0, 0, 0);
      run_phase(150, 47, 0, 0);
      run_phase(150, 0, 47, 0);
      run_phase(150, 28, 28, 0);
      // The receiver holds off for a long stretch while requests keep coming.
      run_phase(60, 0, 0, 400);
      run_phase(70, 0, 0, 0);

      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/ffha_pkg.sv
sv/ffha_hdr_ram.sv
sv/first_fit_heap_allocator.sv
bench/tb_first_fit_heap_allocator.sv
